FILE: hdl/htc_pkg.sv
// Shared types, codes and constants of the heading turn controller.
package htc_pkg;

  localparam int unsigned HEADING_W = 12;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned THRESH_W  = 11;
  localparam int unsigned SPEED_W   = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PWM_W     = 11;
  localparam int unsigned COUNT_W   = LIMIT_W + 1;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 3;

  // Request opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_IDLE    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TURNING = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_REACHED = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_ERROR   = 3'd4;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAST   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SLOW   = 3'd4;

  // Register reset values.
  localparam logic [HEADING_W-1:0] RST_TARGET = 12'd0;
  localparam logic [LIMIT_W-1:0]   RST_LIMIT  = 10'd600;
  localparam logic [THRESH_W-1:0]  RST_THRESH = 11'd100;
  localparam logic [SPEED_W-1:0]   RST_FAST   = 7'd100;
  localparam logic [SPEED_W-1:0]   RST_SLOW   = 7'd35;

  // Angle constants in tenths of a degree.
  localparam logic [HEADING_W-1:0]        HALF_TURN = 12'd1800;
  localparam logic signed [HEADING_W:0]   FULL_TURN = 13'sd3600;
  localparam logic [SPEED_W-1:0]          SPEED_MAX = 7'd100;

  // floor(s * 1024 / 100) = floor(s * 5243 / 512) for s up to 100.
  localparam logic [12:0] PWM_RECIP = 13'd5243;

  typedef struct packed {
    logic [HEADING_W-1:0] target_heading;
    logic [LIMIT_W-1:0]   tick_limit;
    logic [THRESH_W-1:0]  near_threshold;
    logic [SPEED_W-1:0]   fast_speed;
    logic [SPEED_W-1:0]   slow_speed;
  } cfg_t;

  typedef struct packed {
    logic                 opcode;
    logic [HEADING_W-1:0] heading;
    logic                 reading_error;
  } req_t;

  typedef struct packed {
    logic                busy;
    logic                slowed;
    logic                start_negative;
    logic [COUNT_W-1:0]  tick_count;
    logic [SPEED_W-1:0]  current_speed;
    logic                spin_left;
  } turn_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SPEED_W-1:0]  speed_percent;
    logic [PWM_W-1:0]    pwm_duty;
    logic                right_dir;
    logic                left_dir;
  } res_t;

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
    return (s > SPEED_MAX) ? SPEED_MAX : s;
  endfunction

  function automatic logic [PWM_W-1:0] pwm_of(input logic [SPEED_W-1:0] s);
    logic [19:0] prod;
    prod = 20'(s) * 20'(PWM_RECIP);
    return prod[19:9];
  endfunction

endpackage

FILE: hdl/htc_if.sv
// Request and result channel interfaces of the heading turn controller.
interface htc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [htc_pkg::HEADING_W-1:0]  heading;
  logic                           reading_error;

  modport source (output valid, opcode, heading, reading_error, input ready);
  modport sink (input valid, opcode, heading, reading_error, output ready);
endinterface

interface htc_out_if;
  logic                           valid;
  logic                           ready;
  logic [htc_pkg::STATUS_W-1:0]   status;
  logic [htc_pkg::SPEED_W-1:0]    speed_percent;
  logic [htc_pkg::PWM_W-1:0]      pwm_duty;
  logic                           right_dir;
  logic                           left_dir;

  modport source (output valid, status, speed_percent, pwm_duty, right_dir, left_dir,
                  input ready);
  modport sink (input valid, status, speed_percent, pwm_duty, right_dir, left_dir,
                output ready);
endinterface

FILE: hdl/htc_cfg.sv
// APB-style configuration register file of the heading turn controller.
module htc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htc_pkg::ADDR_W-1:0]   paddr,
  input  logic [htc_pkg::DATA_W-1:0]   pwdata,
  output logic [htc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output htc_pkg::cfg_t                cfg
);

  htc_pkg::cfg_t                     cfg_r;
  logic                              wr_en;
  logic [htc_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[htc_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading <= htc_pkg::RST_TARGET;
      cfg_r.tick_limit     <= htc_pkg::RST_LIMIT;
      cfg_r.near_threshold <= htc_pkg::RST_THRESH;
      cfg_r.fast_speed     <= htc_pkg::RST_FAST;
      cfg_r.slow_speed     <= htc_pkg::RST_SLOW;
    end else if (wr_en) begin
      unique case (idx)
        htc_pkg::REG_TARGET: cfg_r.target_heading <= pwdata[htc_pkg::HEADING_W-1:0];
        htc_pkg::REG_LIMIT:  cfg_r.tick_limit     <= pwdata[htc_pkg::LIMIT_W-1:0];
        htc_pkg::REG_THRESH: cfg_r.near_threshold <= pwdata[htc_pkg::THRESH_W-1:0];
        htc_pkg::REG_FAST:   cfg_r.fast_speed     <= pwdata[htc_pkg::SPEED_W-1:0];
        htc_pkg::REG_SLOW:   cfg_r.slow_speed     <= pwdata[htc_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      htc_pkg::REG_TARGET: prdata = htc_pkg::DATA_W'(cfg_r.target_heading);
      htc_pkg::REG_LIMIT:  prdata = htc_pkg::DATA_W'(cfg_r.tick_limit);
      htc_pkg::REG_THRESH: prdata = htc_pkg::DATA_W'(cfg_r.near_threshold);
      htc_pkg::REG_FAST:   prdata = htc_pkg::DATA_W'(cfg_r.fast_speed);
      htc_pkg::REG_SLOW:   prdata = htc_pkg::DATA_W'(cfg_r.slow_speed);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: hdl/htc_step.sv
// Next-state and result logic for one heading request.
module htc_step (
  input  htc_pkg::cfg_t        cfg,
  input  htc_pkg::turn_state_t st,
  input  htc_pkg::req_t        req,
  output htc_pkg::turn_state_t st_nxt,
  output htc_pkg::res_t        res
);

  logic signed [htc_pkg::HEADING_W:0] base;
  logic [htc_pkg::HEADING_W-1:0]      mag;
  logic signed [htc_pkg::HEADING_W:0] wrap;
  logic [htc_pkg::HEADING_W-1:0]      wrap_mag;
  logic signed [htc_pkg::HEADING_W:0] delta;
  logic [htc_pkg::THRESH_W-1:0]       delta_mag;
  logic                               delta_neg;
  logic [htc_pkg::STATUS_W-1:0]       status;

  // Shortest signed distance, folded into plus or minus half a turn.
  always_comb begin
    base     = $signed({1'b0, req.heading}) - $signed({1'b0, cfg.target_heading});
    mag      = base[htc_pkg::HEADING_W] ? htc_pkg::HEADING_W'(-base)
                                        : base[htc_pkg::HEADING_W-1:0];
    wrap     = $signed({1'b0, mag}) - htc_pkg::FULL_TURN;
    wrap_mag = wrap[htc_pkg::HEADING_W] ? htc_pkg::HEADING_W'(-wrap)
                                        : wrap[htc_pkg::HEADING_W-1:0];
    if (mag > htc_pkg::HALF_TURN) begin
      delta = base[htc_pkg::HEADING_W] ? $signed({1'b0, wrap_mag})
                                       : -$signed({1'b0, wrap_mag});
    end else begin
      delta = base;
    end
    delta_neg = delta[htc_pkg::HEADING_W];
    delta_mag = delta_neg ? htc_pkg::THRESH_W'(-delta) : delta[htc_pkg::THRESH_W-1:0];
  end

  always_comb begin
    st_nxt = st;
    status = htc_pkg::STATUS_TURNING;
    if (req.opcode == htc_pkg::OP_START) begin
      if (req.reading_error) begin
        st_nxt.busy          = 1'b0;
        st_nxt.current_speed = '0;
        status               = htc_pkg::STATUS_ERROR;
      end else begin
        st_nxt.start_negative = delta_neg;
        st_nxt.spin_left      = !delta_neg;
        st_nxt.slowed         = 1'b0;
        st_nxt.tick_count     = '0;
        st_nxt.busy           = 1'b1;
        st_nxt.current_speed  = htc_pkg::clamp_speed(cfg.fast_speed);
        status                = htc_pkg::STATUS_TURNING;
      end
    end else if (!st.busy) begin
      st_nxt.current_speed = '0;
      status               = htc_pkg::STATUS_IDLE;
    end else if (st.tick_count > {1'b0, cfg.tick_limit}) begin
      st_nxt.busy          = 1'b0;
      st_nxt.current_speed = '0;
      status               = htc_pkg::STATUS_TIMEOUT;
    end else begin
      st_nxt.tick_count = st.tick_count + 1'b1;
      if (req.reading_error) begin
        st_nxt.busy          = 1'b0;
        st_nxt.current_speed = '0;
        status               = htc_pkg::STATUS_ERROR;
      end else begin
        if (!st.slowed && (delta_mag <= cfg.near_threshold)) begin
          st_nxt.current_speed = htc_pkg::clamp_speed(cfg.slow_speed);
          st_nxt.slowed        = 1'b1;
        end
        // A zero distance or a change of sign means the target was passed.
        if ((req.heading == cfg.target_heading) || (delta == '0) ||
            (delta_neg != st.start_negative)) begin
          st_nxt.busy          = 1'b0;
          st_nxt.current_speed = '0;
          status               = htc_pkg::STATUS_REACHED;
        end else begin
          status = htc_pkg::STATUS_TURNING;
        end
      end
    end
  end

  always_comb begin
    res.status        = status;
    res.speed_percent = st_nxt.current_speed;
    res.pwm_duty      = htc_pkg::pwm_of(st_nxt.current_speed);
    res.right_dir     = st_nxt.spin_left;
    res.left_dir      = !st_nxt.spin_left;
  end

endmodule

FILE: hdl/heading_turn_controller.sv
// Top level of the heading turn controller: request register, step logic, result register.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+-----------------------------------------
//   in_chan  | sink      | valid / ready        | opcode, heading, reading_error
//   out_chan | source    | valid / ready        | status, speed_percent, pwm_duty,
//            |           |                      | right_dir, left_dir
//   APB      | slave     | psel/penable, pready | paddr, pwdata, prdata (5 registers)
//
// Each request passes from acceptance into the request register, then through the step
// logic into the result register.
// A new request is accepted in every cycle while results are taken, so one request
// per cycle is sustained; the step logic between the two registers sets the clock.
// Reset is synchronous and active low; it clears the turn state, the valid flags and
// the configuration registers, which take their documented defaults.
// When the result is not taken, the result register holds it and the request register
// keeps one further request; in_chan.ready falls only when both are occupied.
module heading_turn_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  htc_in_if.sink                      in_chan,
  htc_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [htc_pkg::ADDR_W-1:0]  paddr,
  input  logic [htc_pkg::DATA_W-1:0]  pwdata,
  output logic [htc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  htc_pkg::cfg_t        cfg;
  htc_pkg::turn_state_t st_r;
  htc_pkg::turn_state_t st_nxt;
  htc_pkg::req_t        req_r;
  htc_pkg::res_t        res_nxt;
  htc_pkg::res_t        res_r;
  logic                 req_valid_r;
  logic                 req_valid_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_free;
  logic                 req_advance;
  logic                 in_accept;

  htc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htc_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .req    (req_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // The result register is free when empty or when its result leaves this cycle.
  assign out_free      = !out_valid_r || out_chan.ready;
  // The stored request is processed, and the turn state updated, as it moves on.
  assign req_advance   = req_valid_r && out_free;
  assign in_chan.ready = !req_valid_r || req_advance;
  assign in_accept     = in_chan.valid && in_chan.ready;

  always_comb begin
    if (in_accept) begin
      req_valid_nxt = 1'b1;
    end else if (req_advance) begin
      req_valid_nxt = 1'b0;
    end else begin
      req_valid_nxt = req_valid_r;
    end

    if (req_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (req_advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.opcode        <= in_chan.opcode;
      req_r.heading       <= in_chan.heading;
      req_r.reading_error <= in_chan.reading_error;
    end
    if (req_advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = res_r.status;
  assign out_chan.speed_percent = res_r.speed_percent;
  assign out_chan.pwm_duty      = res_r.pwm_duty;
  assign out_chan.right_dir     = res_r.right_dir;
  assign out_chan.left_dir      = res_r.left_dir;

endmodule

FILE: hdl/htc_checker.sv
// Port-level assertions for the heading turn controller, bound to the top level.
module htc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [htc_pkg::STATUS_W-1:0] out_status,
  input logic [htc_pkg::SPEED_W-1:0]  out_speed,
  input logic [htc_pkg::PWM_W-1:0]    out_pwm,
  input logic                        out_right,
  input logic                        out_left
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Any result other than turning leaves the motors stopped.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != htc_pkg::STATUS_TURNING) |->
      (out_speed == '0) && (out_pwm == '0))
    else $error("motors driven in a stopped result");

  // The two motors always spin in opposite directions.
  a_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left == !out_right))
    else $error("motor direction bits not complementary");

  // Status code and speed stay in range, and full speed gives the full duty.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= htc_pkg::STATUS_ERROR) &&
      (out_speed <= htc_pkg::SPEED_MAX) &&
      ((out_speed != htc_pkg::SPEED_MAX) || (out_pwm == 11'd1024)))
    else $error("result out of range");

endmodule

bind heading_turn_controller htc_checker u_htc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_speed  (out_chan.speed_percent),
  .out_pwm    (out_chan.pwm_duty),
  .out_right  (out_chan.right_dir),
  .out_left   (out_chan.left_dir)
);

FILE: test/heading_turn_controller_test.sv
// Self-checking testbench for the heading turn controller: directed plan, then random turns.
`timescale 1ns / 100ps

module heading_turn_controller_test;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 4;       // two register stages plus margin
  localparam int MAX_GAP       = 14;
  localparam int LONG_HOLD     = 64;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 55;
  localparam int HEADING_TOP   = 3599;
  localparam int HEADING_ALL   = (1 << htc_pkg::HEADING_W) - 1;
  localparam int LIMIT_ALL     = (1 << htc_pkg::LIMIT_W) - 1;
  localparam int THRESH_ALL    = (1 << htc_pkg::THRESH_W) - 1;
  localparam int THRESH_TOP    = 1800;
  localparam int SPEED_ALL     = (1 << htc_pkg::SPEED_W) - 1;
  localparam int PERCENT_FULL  = 100;
  localparam int PWM_SCALE     = 1024;
  localparam int SHORT_LIMIT   = 40;
  localparam int RUN_LIMIT_NS  = 8_000_000;

  typedef enum logic [2:0] {
    DO_START, DO_TICK, SET_TARGET, SET_LIMIT, SET_THRESH, SET_FAST, SET_SLOW
  } plan_act_t;

  typedef struct packed {
    plan_act_t                      act;
    logic [htc_pkg::HEADING_W-1:0]  arg;     // heading for a request, value for a write
    logic                           bad;     // failed compass reading
    logic                           typed;   // expected result written out below
    htc_pkg::res_t                  want;
  } row_t;

  localparam htc_pkg::res_t UNTYPED = '0;
  localparam int PLAN_ROWS = 25;

  // Directed plan. Register defaults apply until the first write: target 0, limit 600,
  // near threshold 100, speeds 100 and 35.
  row_t directed_plan [PLAN_ROWS] = '{
    '{DO_TICK,    12'd0,    1'b0, 1'b1, {htc_pkg::STATUS_IDLE, 7'd0, 11'd0, 1'b0, 1'b1}},
    '{DO_START,   12'd0,    1'b1, 1'b1, {htc_pkg::STATUS_ERROR, 7'd0, 11'd0, 1'b0, 1'b1}},
    '{DO_START,   12'd0,    1'b0, 1'b1,
      {htc_pkg::STATUS_TURNING, 7'd100, 11'd1024, 1'b1, 1'b0}},
    '{DO_TICK,    12'd0,    1'b0, 1'b1, {htc_pkg::STATUS_REACHED, 7'd0, 11'd0, 1'b1, 1'b0}},
    '{DO_START,   12'd3599, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd3000, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd3550, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd4095, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd5,    1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd1234, 1'b1, 1'b0, UNTYPED},
    '{DO_START,   12'd1800, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd1801, 1'b0, 1'b0, UNTYPED},
    '{DO_START,   12'd900,  1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd700,  1'b1, 1'b1, {htc_pkg::STATUS_ERROR, 7'd0, 11'd0, 1'b1, 1'b0}},
    '{SET_LIMIT,  12'd0,    1'b0, 1'b0, UNTYPED},
    '{SET_FAST,   12'd127,  1'b0, 1'b0, UNTYPED},
    '{SET_SLOW,   12'd0,    1'b0, 1'b0, UNTYPED},
    '{SET_THRESH, 12'd1800, 1'b0, 1'b0, UNTYPED},
    '{SET_TARGET, 12'd4095, 1'b0, 1'b0, UNTYPED},
    '{DO_START,   12'd2000, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd2100, 1'b0, 1'b0, UNTYPED},
    '{DO_TICK,    12'd2100, 1'b0, 1'b1, {htc_pkg::STATUS_TIMEOUT, 7'd0, 11'd0, 1'b1, 1'b0}},
    '{DO_START,   12'd100,  1'b0, 1'b0, UNTYPED},
    '{DO_START,   12'd3000, 1'b0, 1'b0, UNTYPED},
    '{SET_THRESH, 12'd0,    1'b0, 1'b0, UNTYPED}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [htc_pkg::ADDR_W-1:0] paddr;
  logic [htc_pkg::DATA_W-1:0] pwdata, prdata;
  logic pready;

  htc_in_if  in_chan ();
  htc_out_if out_chan ();

  heading_turn_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // The testbench's own view of the registers and of the turn in progress.
  htc_pkg::cfg_t        settings = '{htc_pkg::RST_TARGET, htc_pkg::RST_LIMIT,
                                     htc_pkg::RST_THRESH, htc_pkg::RST_FAST,
                                     htc_pkg::RST_SLOW};
  htc_pkg::turn_state_t turn = '0;

  htc_pkg::res_t awaited_motor_results [$];
  bit   steady = 1'b0;             // both sides run without idling
  bit   hold_off_pending = 1'b0;   // the result side is to stall for a long stretch
  int   requests_sent = 0;
  int   results_checked = 0;
  int   failures = 0;
  int   writes = 0;
  int   status_seen [8] = '{default: 0};

  // Shortest signed distance from target to reading, folded into +-half a turn.
  function automatic int fold_angle(input int cur, input int tgt);
    int base, mag, r;
    base = cur - tgt;
    mag = (base < 0) ? -base : base;
    if (mag > int'(htc_pkg::HALF_TURN)) begin
      r = mag - int'(htc_pkg::FULL_TURN);
      if (r < 0) r = -r;
      return (base < 0) ? r : -r;
    end
    return base;
  endfunction

  function automatic logic [htc_pkg::SPEED_W-1:0] capped_speed(
      input logic [htc_pkg::SPEED_W-1:0] s);
    if (int'(s) > PERCENT_FULL) return htc_pkg::SPEED_MAX;
    return s;
  endfunction

  function automatic htc_pkg::res_t motor_result(input logic [htc_pkg::STATUS_W-1:0] st);
    htc_pkg::res_t o;
    o.status        = st;
    o.speed_percent = turn.current_speed;
    o.pwm_duty      = htc_pkg::PWM_W'((int'(turn.current_speed) * PWM_SCALE) / PERCENT_FULL);
    o.right_dir     = turn.spin_left;
    o.left_dir      = !turn.spin_left;
    return o;
  endfunction

  // Motors stop but the direction bits keep the last spin.
  function automatic htc_pkg::res_t halted(input logic [htc_pkg::STATUS_W-1:0] st);
    turn.busy = 1'b0;
    turn.current_speed = '0;
    return motor_result(st);
  endfunction

  function automatic htc_pkg::res_t predict_motor_command(input htc_pkg::req_t r);
    int d, mag;
    if (r.opcode == htc_pkg::OP_START) begin
      if (r.reading_error) return halted(htc_pkg::STATUS_ERROR);
      // A start drops any turn in progress; zero distance counts as a left spin.
      d = fold_angle(int'(r.heading), int'(settings.target_heading));
      turn.start_negative = (d < 0);
      turn.spin_left      = !(d < 0);
      turn.slowed         = 1'b0;
      turn.tick_count     = '0;
      turn.busy           = 1'b1;
      turn.current_speed  = capped_speed(settings.fast_speed);
      return motor_result(htc_pkg::STATUS_TURNING);
    end
    if (!turn.busy) begin
      turn.current_speed = '0;
      return motor_result(htc_pkg::STATUS_IDLE);
    end
    // The limit is checked before this tick is counted.
    if (turn.tick_count > settings.tick_limit) return halted(htc_pkg::STATUS_TIMEOUT);
    turn.tick_count = turn.tick_count + 1'b1;
    if (r.reading_error) return halted(htc_pkg::STATUS_ERROR);
    d = fold_angle(int'(r.heading), int'(settings.target_heading));
    mag = (d < 0) ? -d : d;
    if (!turn.slowed && mag <= int'(settings.near_threshold)) begin
      turn.current_speed = capped_speed(settings.slow_speed);
      turn.slowed = 1'b1;
    end
    if (r.heading == settings.target_heading || d == 0 || (d < 0) != turn.start_negative)
      return halted(htc_pkg::STATUS_REACHED);
    return motor_result(htc_pkg::STATUS_TURNING);
  endfunction

  function automatic htc_pkg::req_t request(input logic op, input int hd, input logic bad);
    htc_pkg::req_t r;
    r.opcode        = op;
    r.heading       = htc_pkg::HEADING_W'(hd);
    r.reading_error = bad;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  function automatic int draw_setting(input int top);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // Offers one request after a random gap and records its expected result once accepted.
  task automatic send_request(input htc_pkg::req_t r, input bit typed,
                              input htc_pkg::res_t typed_res,
                              output logic [htc_pkg::STATUS_W-1:0] st);
    int            gap;
    htc_pkg::res_t predicted;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.opcode        <= r.opcode;
    in_chan.heading       <= r.heading;
    in_chan.reading_error <= r.reading_error;
    do @(posedge clk); while (!in_chan.ready);
    predicted = predict_motor_command(r);
    awaited_motor_results.push_back(typed ? typed_res : predicted);
    st = predicted.status;
    requests_sent++;
  endtask

  // Stops offering requests and waits until the block has nothing left in flight.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (awaited_motor_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write with read-back, done only once the block has drained.
  task automatic write_reg(input logic [htc_pkg::REG_IDX_W-1:0] idx,
                           input logic [htc_pkg::DATA_W-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      htc_pkg::REG_TARGET: settings.target_heading = value[htc_pkg::HEADING_W-1:0];
      htc_pkg::REG_LIMIT:  settings.tick_limit     = value[htc_pkg::LIMIT_W-1:0];
      htc_pkg::REG_THRESH: settings.near_threshold = value[htc_pkg::THRESH_W-1:0];
      htc_pkg::REG_FAST:   settings.fast_speed     = value[htc_pkg::SPEED_W-1:0];
      htc_pkg::REG_SLOW:   settings.slow_speed     = value[htc_pkg::SPEED_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    writes++;
  endtask

  // One turn: a start, then ticks that mostly close in on the target, with failed
  // readings, wild readings and restarts mixed in, then a few ticks while idle.
  task automatic run_turn();
    int   h, step, d;
    logic op, bad;
    logic [htc_pkg::STATUS_W-1:0] st;
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, HEADING_ALL)
                                    : $urandom_range(0, HEADING_TOP);
    send_request(request(htc_pkg::OP_START, h, $urandom_range(0, 15) == 0), 1'b0, UNTYPED,
                 st);
    while (st == htc_pkg::STATUS_TURNING) begin
      op  = htc_pkg::OP_TICK;
      bad = 1'b0;
      case ($urandom_range(0, 31))
        0: bad = 1'b1;
        1: h = $urandom_range(0, HEADING_ALL);
        2: begin
          op = htc_pkg::OP_START;
          h  = $urandom_range(0, HEADING_TOP);
        end
        default: begin
          step = $urandom_range(0, 250);
          d = fold_angle(h, int'(settings.target_heading));
          if (((d < 0) ? -d : d) <= step && $urandom_range(0, 1))
            h = int'(settings.target_heading);
          else begin
            h = (d >= 0) ? h - step : h + step;
            h = (h + int'(htc_pkg::FULL_TURN)) % int'(htc_pkg::FULL_TURN);
          end
        end
      endcase
      send_request(request(op, h, bad), 1'b0, UNTYPED, st);
    end
    repeat ($urandom_range(0, 2))
      send_request(request(htc_pkg::OP_TICK, $urandom_range(0, HEADING_ALL),
                           1'($urandom_range(0, 1))),
                   1'b0, UNTYPED, st);
  endtask

  initial begin : stimulus
    row_t row;
    logic [htc_pkg::STATUS_W-1:0] st;
    int   aim, far, phase_start;
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_chan.valid         <= 1'b0;
    in_chan.opcode        <= htc_pkg::OP_START;
    in_chan.heading       <= '0;
    in_chan.reading_error <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan: extremes of the fields, every opcode and the corner cases.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = directed_plan[i];
      case (row.act)
        DO_START, DO_TICK:
          send_request(request((row.act == DO_TICK) ? htc_pkg::OP_TICK : htc_pkg::OP_START,
                               int'(row.arg), row.bad),
                       row.typed, row.want, st);
        SET_TARGET: write_reg(htc_pkg::REG_TARGET, htc_pkg::DATA_W'(row.arg));
        SET_LIMIT:  write_reg(htc_pkg::REG_LIMIT, htc_pkg::DATA_W'(row.arg));
        SET_THRESH: write_reg(htc_pkg::REG_THRESH, htc_pkg::DATA_W'(row.arg));
        SET_FAST:   write_reg(htc_pkg::REG_FAST, htc_pkg::DATA_W'(row.arg));
        SET_SLOW:   write_reg(htc_pkg::REG_SLOW, htc_pkg::DATA_W'(row.arg));
        default: ;
      endcase
    end

    // Random phases, each under fresh settings. Some phases run without idling, and one
    // of them asks the result side for a long stall so that the block backs up.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(htc_pkg::REG_TARGET, ($urandom_range(0, 5) == 0)
                                     ? $urandom_range(HEADING_TOP + 1, HEADING_ALL)
                                     : draw_setting(HEADING_TOP));
      write_reg(htc_pkg::REG_LIMIT, $urandom_range(0, 1) ? draw_setting(SHORT_LIMIT)
                                                         : draw_setting(LIMIT_ALL));
      write_reg(htc_pkg::REG_THRESH, ($urandom_range(0, 5) == 0)
                                     ? $urandom_range(THRESH_TOP + 1, THRESH_ALL)
                                     : draw_setting(THRESH_TOP));
      write_reg(htc_pkg::REG_FAST, draw_setting(SPEED_ALL));
      write_reg(htc_pkg::REG_SLOW, draw_setting(SPEED_ALL));
      steady = (p % 4 == 2);
      if (p == 2) hold_off_pending = 1'b1;
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) run_turn();
    end
    steady = 1'b0;

    // One turn that never gets near the target, so the widest limit runs out.
    aim = $urandom_range(0, HEADING_TOP);
    write_reg(htc_pkg::REG_TARGET, aim);
    write_reg(htc_pkg::REG_LIMIT, LIMIT_ALL);
    write_reg(htc_pkg::REG_THRESH, $urandom_range(0, 500));
    write_reg(htc_pkg::REG_FAST, $urandom_range(0, SPEED_ALL));
    write_reg(htc_pkg::REG_SLOW, $urandom_range(0, SPEED_ALL));
    far = (aim + 900) % int'(htc_pkg::FULL_TURN);
    send_request(request(htc_pkg::OP_START, far, 1'b0), 1'b0, UNTYPED, st);
    while (st == htc_pkg::STATUS_TURNING)
      send_request(request(htc_pkg::OP_TICK,
                           (far + int'(htc_pkg::FULL_TURN) + $urandom_range(0, 600) - 300)
                           % int'(htc_pkg::FULL_TURN), 1'b0), 1'b0, UNTYPED, st);

    in_chan.valid <= 1'b0;
    while (awaited_motor_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d reached, %0d timeouts, %0d errors.",
             requests_sent, results_checked, status_seen[htc_pkg::STATUS_REACHED],
             status_seen[htc_pkg::STATUS_TIMEOUT], status_seen[htc_pkg::STATUS_ERROR]);
    $display("Ticks while idle: %0d; register writes with read-back: %0d.",
             status_seen[htc_pkg::STATUS_IDLE], writes);
    if (failures == 0) begin
      $display("heading_turn_controller verification clean");
    end else begin
      $display("heading_turn_controller verification failed");
    end
    $finish;
  end

  // Result side: a random stall before each result, none in steady phases, and one long
  // hold-off on request from the stimulus.
  initial begin : result_taker
    int stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_pending) begin
        stall = LONG_HOLD;
        hold_off_pending = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Every result taken is matched against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    htc_pkg::res_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (awaited_motor_results.size() == 0) begin
        $error("result with no request outstanding, status %0d", out_chan.status);
        failures++;
      end else begin
        want = awaited_motor_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_chan.status));
        check_field("speed_percent", 32'(want.speed_percent), 32'(out_chan.speed_percent));
        check_field("pwm_duty", 32'(want.pwm_duty), 32'(out_chan.pwm_duty));
        check_field("right_dir", 32'(want.right_dir), 32'(out_chan.right_dir));
        check_field("left_dir", 32'(want.left_dir), 32'(out_chan.left_dir));
        status_seen[want.status]++;
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("heading_turn_controller verification failed");
    $finish;
  end

endmodule
